### hdl/mdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdl_pkg: motor deadband linearizer shared definitions
// Fixed-point type, Q.28 coefficients and the rounded multiply helper.
// ----------------------------------------------------------------------------
package mdl_pkg;

   // Q2.FRAC_BITS command and drive format
   localparam int FRAC_BITS = 14;
   // internal fraction bits
   localparam int QB        = 28;
   localparam int SHIFT     = QB - FRAC_BITS;
   localparam int QW        = 36;
   localparam int LATENCY   = 10;

   typedef logic signed [QW-1:0]   q_type;
   typedef logic signed [2*QW-1:0] qprod_type;

   localparam q_type Q_ONE    = q_type'(1) <<< QB;
   localparam q_type Q_HALF   = q_type'(1) <<< (QB - 1);
   localparam q_type OUT_HALF = q_type'(1) <<< (SHIFT - 1);
   localparam q_type K_DB     = 36'sd22011707;
   localparam q_type K_INV    = 36'sd292413351;
   localparam q_type K_E1     = 36'sd117370450;
   localparam q_type K_C1     = -36'sd421032960;
   localparam q_type K_A1     = 36'sd552770612;
   localparam q_type K_C2     = -36'sd1468043981;
   localparam q_type K_E2     = 36'sd601869873;
   localparam q_type K_G2     = -36'sd11374952;
   localparam q_type K_A2     = 36'sd1126657163;
   localparam q_type K_MEAN   = 36'sd114085069;
   localparam q_type K_LIN    = 36'sd36963562;
   localparam q_type K_TINY   = 36'sd268435;
   localparam q_type X_LIMIT  = 36'sd402653184;

   // full-scale drive in the output format
   localparam logic signed [15:0] OUT_ONE = 16'sd1 <<< FRAC_BITS;

   // Q.28 product, rounded half up (floor after adding one half LSB)
   function automatic q_type qmul(input q_type a, input q_type b);
      qprod_type p;
      p = qprod_type'(a) * qprod_type'(b) + qprod_type'(Q_HALF);
      return p[QB+QW-1:QB];
   endfunction

endpackage

### hdl/motor_deadband_linearizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_deadband_linearizer: deadband removal and polynomial linearization
// Throughput: one command per cycle; busy stays low, the ten-stage multiplier
// pipeline takes a new command at every edge.
// Reset: synchronous, active high; clears all stage valid bits and sets
// invert_output to 0. The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module motor_deadband_linearizer
   import mdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_speed_command,
   // result channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_drive_value,
   output logic               rsp_saturated,
   // configuration write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_invert_output
);

   logic                 accept;
   logic [LATENCY-1:0]   valid_ff, valid_in;
   logic                 invert_ff, invert_in;

   // stage payload registers
   q_type x1_ff, x1_in;                 // deadband removed
   q_type x2_ff, x2_in;                 // rescaled, clipped x
   q_type xa3_ff, xa3_in, sq3_ff, sq3_in;
   q_type xa4_ff, xa4_in, sq4_ff, sq4_in, t5a_ff, t5a_in, t7a_ff, t7a_in;
   q_type xa5_ff, xa5_in, sq5_ff, sq5_in, t5b_ff, t5b_in, t7b_ff, t7b_in;
   q_type xa6_ff, xa6_in, p5_6_ff, p5_6_in, t7c_ff, t7c_in;
   q_type xa7_ff, xa7_in, p5_7_ff, p5_7_in, p7_ff, p7_in;
   q_type mean_ff, mean_in, lin_ff, lin_in;
   q_type ans_ff, ans_in;
   logic signed [15:0] drive_ff, drive_in;
   logic               sat_ff, sat_in;

   // datapath temporaries
   q_type cmd_q, xmul, sum9, lim, inv, rnd;
   logic  sat;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // configuration register
   always_comb begin
      invert_in = invert_ff;
      if (csr_valid && csr_ready) begin
         invert_in = csr_invert_output;
      end
   end

   // valid bits travel with the data
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   // pipeline datapath
   always_comb begin
      // stage 1: align to Q.28 and strip the deadband
      cmd_q = q_type'(req_speed_command) <<< SHIFT;
      if (cmd_q > K_DB) begin
         x1_in = cmd_q - K_DB;
      end else if (cmd_q < -K_DB) begin
         x1_in = cmd_q + K_DB;
      end else begin
         x1_in = '0;
      end

      // stage 2: rescale and clip to +-1.5
      xmul = qmul(x1_ff, K_INV);
      if (xmul > X_LIMIT) begin
         x2_in = X_LIMIT;
      end else if (xmul < -X_LIMIT) begin
         x2_in = -X_LIMIT;
      end else begin
         x2_in = xmul;
      end

      // stage 3: square
      xa3_in = x2_ff;
      sq3_in = qmul(x2_ff, x2_ff);

      // stage 4: innermost Horner terms
      xa4_in = xa3_ff;
      sq4_in = sq3_ff;
      t5a_in = qmul(sq3_ff, K_A1);
      t7a_in = qmul(sq3_ff, K_A2);

      // stage 5
      xa5_in = xa4_ff;
      sq5_in = sq4_ff;
      t5b_in = qmul(sq4_ff, K_C1 + t5a_ff);
      t7b_in = qmul(sq4_ff, K_C2 + t7a_ff);

      // stage 6: p5 finishes, p7 continues
      xa6_in  = xa5_ff;
      p5_6_in = qmul(xa5_ff, K_E1 + t5b_ff);
      t7c_in  = qmul(sq5_ff, K_E2 + t7b_ff);

      // stage 7: p7 finishes
      xa7_in  = xa6_ff;
      p5_7_in = p5_6_ff;
      p7_in   = qmul(xa6_ff, K_G2 + t7c_ff);

      // stage 8: blend weights
      mean_in = qmul(K_MEAN, p5_7_ff + p7_ff);
      lin_in  = qmul(K_LIN, xa7_ff);

      // stage 9: sum and restore the deadband outside the tiny band
      sum9 = mean_ff + lin_ff;
      if (sum9 > K_TINY) begin
         ans_in = sum9 + K_DB;
      end else if (sum9 < -K_TINY) begin
         ans_in = sum9 - K_DB;
      end else begin
         ans_in = sum9;
      end

      // stage 10: saturate, optional invert, round to output format
      sat = 1'b0;
      lim = ans_ff;
      if (ans_ff > Q_ONE) begin
         lim = Q_ONE;
         sat = 1'b1;
      end else if (ans_ff < -Q_ONE) begin
         lim = -Q_ONE;
         sat = 1'b1;
      end
      inv      = invert_ff ? -lim : lim;
      rnd      = inv + OUT_HALF;
      drive_in = rnd[SHIFT+15:SHIFT];
      sat_in   = sat;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         invert_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         invert_ff <= invert_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x1_ff   <= x1_in;
      x2_ff   <= x2_in;
      xa3_ff  <= xa3_in;
      sq3_ff  <= sq3_in;
      xa4_ff  <= xa4_in;
      sq4_ff  <= sq4_in;
      t5a_ff  <= t5a_in;
      t7a_ff  <= t7a_in;
      xa5_ff  <= xa5_in;
      sq5_ff  <= sq5_in;
      t5b_ff  <= t5b_in;
      t7b_ff  <= t7b_in;
      xa6_ff  <= xa6_in;
      p5_6_ff <= p5_6_in;
      t7c_ff  <= t7c_in;
      xa7_ff  <= xa7_in;
      p5_7_ff <= p5_7_in;
      p7_ff   <= p7_in;
      mean_ff <= mean_in;
      lin_ff  <= lin_in;
      ans_ff  <= ans_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
   end

   assign rsp_valid       = valid_ff[LATENCY-1];
   assign rsp_drive_value = drive_ff;
   assign rsp_saturated   = sat_ff;

   // checks
   // a result strobe always traces back to a command transfer
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching command");

   // a clipped result sits exactly on a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_drive_value == OUT_ONE || rsp_drive_value == -OUT_ONE))
      else $error("saturated result not at full scale");

   // drive never exceeds full scale
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_value <= OUT_ONE && rsp_drive_value >= -OUT_ONE))
      else $error("drive value out of range");

   // reset leaves no result in flight
   a_reset_flush: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

### test/motor_deadband_linearizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_deadband_linearizer_checker: drive value scoreboard
// Watches the command, result and register channels of the linearizer. On
// every accepted command it computes the expected drive value and clip flag
// in 64-bit Q.28 arithmetic, then compares each result strobe against the
// oldest prediction. Reports the mismatch count and the number of
// predictions still in flight.
// ----------------------------------------------------------------------------
module motor_deadband_linearizer_checker
   import mdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_speed_command,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_drive_value,
   input  logic               rsp_saturated,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_invert_output,
   output int                 mismatch_count,
   output int                 pending_count
);

   // coefficients widened to 64 bits
   localparam longint DEADBAND  = K_DB;
   localparam longint RESCALE   = K_INV;
   localparam longint P5_E      = K_E1;
   localparam longint P5_C      = K_C1;
   localparam longint P5_A      = K_A1;
   localparam longint P7_G      = K_G2;
   localparam longint P7_E      = K_E2;
   localparam longint P7_C      = K_C2;
   localparam longint P7_A      = K_A2;
   localparam longint MEAN_GAIN = K_MEAN;
   localparam longint LIN_GAIN  = K_LIN;
   localparam longint TINY      = K_TINY;
   localparam longint X_CLIP    = X_LIMIT;
   localparam longint UNITY     = longint'(1) <<< QB;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               saturated;
   } drive_result_type;

   drive_result_type expected_drives[$];
   logic             invert_q = 1'b0;

   // Q.28 product, half-up rounding then floor
   function automatic longint round_mul(input longint a, input longint b);
      return (a * b + (longint'(1) <<< (QB - 1))) >>> QB;
   endfunction

   function automatic drive_result_type linearize(input logic signed [15:0] cmd,
                                                  input logic invert);
      longint           x;
      longint           x2;
      longint           p5;
      longint           p7;
      longint           blend;
      drive_result_type r;
      r.saturated = 1'b0;
      x = longint'(cmd) <<< SHIFT;
      // strip the deadband, rescale, clip to +-1.5
      if (x > DEADBAND)
         x = x - DEADBAND;
      else if (x < -DEADBAND)
         x = x + DEADBAND;
      else
         x = 0;
      x = round_mul(x, RESCALE);
      if (x > X_CLIP)
         x = X_CLIP;
      else if (x < -X_CLIP)
         x = -X_CLIP;
      // odd polynomials, Horner in x^2
      x2    = round_mul(x, x);
      p5    = round_mul(x, P5_E + round_mul(x2, P5_C + round_mul(x2, P5_A)));
      p7    = round_mul(x, P7_G + round_mul(x2, P7_E + round_mul(x2, P7_C +
                                                      round_mul(x2, P7_A))));
      blend = round_mul(MEAN_GAIN, p5 + p7) + round_mul(LIN_GAIN, x);
      // put the deadband back unless the blend is tiny
      if (blend > TINY)
         blend = blend + DEADBAND;
      else if (blend < -TINY)
         blend = blend - DEADBAND;
      if (blend > UNITY) begin
         blend       = UNITY;
         r.saturated = 1'b1;
      end else if (blend < -UNITY) begin
         blend       = -UNITY;
         r.saturated = 1'b1;
      end
      if (invert)
         blend = -blend;
      blend   = (blend + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
      r.drive = blend[15:0];
      return r;
   endfunction

   // track register, queue predictions, compare results
   always @(posedge clock) begin : watch_channels
      drive_result_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         expected_drives.delete();
         invert_q       <= 1'b0;
         mismatch_count <= 0;
         pending_count  <= 0;
      end else begin
         if (csr_valid && csr_ready)
            invert_q <= csr_invert_output;
         if (start && !busy)
            expected_drives.push_back(linearize(req_speed_command, invert_q));
         if (rsp_valid) begin
            if (expected_drives.size() == 0) begin
               $error("unexpected result: drive_value %0d saturated %0d",
                      rsp_drive_value, rsp_saturated);
               errs++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive_value !== want.drive) begin
                  $error("drive_value: expected %0d, got %0d",
                         want.drive, rsp_drive_value);
                  errs++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d",
                         want.saturated, rsp_saturated);
                  errs++;
               end
            end
         end
         mismatch_count <= mismatch_count + errs;
         pending_count  <= expected_drives.size();
      end
   end

endmodule

### test/motor_deadband_linearizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_deadband_linearizer_test: top-level testbench
// Drives speed commands through the linearizer with random gaps and burst
// stretches, toggles the invert register between phases, and leaves checking
// to the scoreboard. Directed commands cover the range ends, deadband edges,
// tiny blends and saturation; random ones cover the full range plus the
// deadband and clip regions.
// ----------------------------------------------------------------------------
module motor_deadband_linearizer_test
   import mdl_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 345;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               start             = 1'b0;
   logic               busy;
   logic signed [15:0] req_speed_command = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_drive_value;
   logic               rsp_saturated;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic               csr_invert_output = 1'b0;

   int                 mismatch_count;
   int                 pending_count;
   int                 cycle_count       = 0;
   bit                 burst_mode        = 1'b0;

   logic signed [15:0] directed_cmds[$] = '{
      -16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1,
      16'sd1343, 16'sd1344, -16'sd1343, -16'sd1344,
      16'sd1350, -16'sd1350, 16'sd1400, -16'sd1400,
      16'sd8192, -16'sd8192, 16'sd15000, -16'sd15000,
      16'sd16383, 16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385
   };

   always #4 clock = ~clock;

   motor_deadband_linearizer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_speed_command (req_speed_command),
      .rsp_valid         (rsp_valid),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_saturated     (rsp_saturated),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_invert_output (csr_invert_output)
   );

   motor_deadband_linearizer_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_speed_command (req_speed_command),
      .rsp_valid         (rsp_valid),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_saturated     (rsp_saturated),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_invert_output (csr_invert_output),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one command transfer, preceded by a random gap unless bursting
   task automatic send_command(input logic signed [15:0] cmd);
      int gap;
      if ($urandom_range(0, 31) == 0)
         burst_mode = !burst_mode;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             <= 1'b1;
      req_speed_command <= cmd;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // random command: full range mostly, weighted toward deadband and clip
   function automatic logic signed [15:0] pick_command();
      int                 kind;
      logic signed [15:0] mag;
      kind = $urandom_range(0, 19);
      if (kind < 10)
         return 16'($urandom_range(0, 65535));
      else if (kind < 14)
         mag = 16'($urandom_range(1243, 1543));
      else if (kind < 17)
         mag = 16'($urandom_range(12000, 17000));
      else
         mag = 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 1))
         mag = -mag;
      return mag;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_command(pick_command());
   endtask

   // drop start and let every outstanding result drain
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_invert(input logic value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_invert_output <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed commands on a reversed motor
      write_invert(1'b1);
      foreach (directed_cmds[i])
         send_command(directed_cmds[i]);
      settle();

      // random phases across both register settings
      write_invert(1'b0);
      run_random(PHASE_ITEMS);
      settle();
      write_invert(1'b1);
      run_random(PHASE_ITEMS);
      settle();
      write_invert(1'b0);
      run_random(PHASE_ITEMS);
      settle();

      // catch stray strobes after the last result
      repeat (LATENCY + 6) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
hdl/mdl_pkg.sv
hdl/motor_deadband_linearizer.sv
test/motor_deadband_linearizer_checker.sv
test/motor_deadband_linearizer_test.sv
